// ----- src/sha1sh_pkg.sv -----
// shared types, constants and round functions of the sha-1 stream hasher
package sha1sh_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_INIT0 = 3'd0;
    localparam logic [2:0] CFG_INIT1 = 3'd1;
    localparam logic [2:0] CFG_INIT2 = 3'd2;
    localparam logic [2:0] CFG_INIT3 = 3'd3;
    localparam logic [2:0] CFG_INIT4 = 3'd4;
    localparam logic [2:0] CFG_PRIOR = 3'd5;

    localparam int CFG_DATA_W  = 55;
    localparam int CFG_INDEX_W = 3;

    // reset values of the configuration registers
    localparam logic [31:0] INIT0_RST = 32'he384efad;
    localparam logic [31:0] INIT1_RST = 32'hf26767a6;
    localparam logic [31:0] INIT2_RST = 32'h13162142;
    localparam logic [31:0] INIT3_RST = 32'hb5ef0efb;
    localparam logic [31:0] INIT4_RST = 32'hb9d7659a;
    localparam logic [54:0] PRIOR_RST = 55'd2;

    // round constants
    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [6:0] ROUND_LAST = 7'd79;
    localparam logic [5:0] POS_LAST   = 6'd63;
    localparam logic [5:0] POS_LEN    = 6'd56;
    localparam logic [2:0] WORD_LAST  = 3'd4;
    localparam logic [7:0] PAD_MARK   = 8'h80;

    // round group codes
    typedef logic [1:0] round_grp_t;
    localparam round_grp_t GRP_CH  = 2'd0;
    localparam round_grp_t GRP_PAR = 2'd1;
    localparam round_grp_t GRP_MAJ = 2'd2;
    localparam round_grp_t GRP_PR2 = 2'd3;

    // byte source codes for the block buffer
    typedef logic [1:0] byte_sel_t;
    localparam byte_sel_t SEL_DATA = 2'd0;
    localparam byte_sel_t SEL_MARK = 2'd1;
    localparam byte_sel_t SEL_ZERO = 2'd2;
    localparam byte_sel_t SEL_LEN  = 2'd3;

    // commands from the controller to the datapath
    typedef struct packed {
        logic       start;
        logic       byte_we;
        byte_sel_t  byte_sel;
        logic       add_count;
        logic       latch_total;
        logic       load_work;
        logic       round_en;
        round_grp_t grp;
        logic       cv_add;
        logic [2:0] word_idx;
    } cmd_t;

    // round function
    function automatic logic [31:0] sha1_f(input round_grp_t grp, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
        logic [31:0] r;
        unique case (grp)
            GRP_CH:  r = (b & (c ^ d)) ^ d;
            GRP_MAJ: r = (b & c) | ((b | c) & d);
            default: r = b ^ c ^ d;
        endcase
        return r;
    endfunction

    // round constant
    function automatic logic [31:0] sha1_k(input round_grp_t grp);
        logic [31:0] r;
        unique case (grp)
            GRP_CH:  r = K0;
            GRP_PAR: r = K1;
            GRP_MAJ: r = K2;
            default: r = K3;
        endcase
        return r;
    endfunction

endpackage

// ----- src/sha1sh_datapath.sv -----
// datapath: configuration, block buffer, message schedule, rounds and chaining value
module sha1sh_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [sha1sh_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [sha1sh_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [7:0]                          data_byte,
    input  sha1sh_pkg::cmd_t                    cmd,
    output logic [31:0]                         digest_word
);

    logic [31:0]  init_reg [5];
    logic [54:0]  prior_reg;
    logic [31:0]  cv_reg [5];
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [511:0] buf_reg;
    logic [63:0]  count_reg;
    logic [63:0]  total_reg;

    logic [63:0]  count_base;
    logic [63:0]  count_next;
    logic [7:0]   byte_in;
    logic [31:0]  w_now;
    logic [31:0]  w_mix;
    logic [31:0]  w_new;
    logic [31:0]  t_sum;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_reg[0] <= sha1sh_pkg::INIT0_RST;
            init_reg[1] <= sha1sh_pkg::INIT1_RST;
            init_reg[2] <= sha1sh_pkg::INIT2_RST;
            init_reg[3] <= sha1sh_pkg::INIT3_RST;
            init_reg[4] <= sha1sh_pkg::INIT4_RST;
            prior_reg   <= sha1sh_pkg::PRIOR_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                sha1sh_pkg::CFG_INIT0: init_reg[0] <= cfg_data[31:0];
                sha1sh_pkg::CFG_INIT1: init_reg[1] <= cfg_data[31:0];
                sha1sh_pkg::CFG_INIT2: init_reg[2] <= cfg_data[31:0];
                sha1sh_pkg::CFG_INIT3: init_reg[3] <= cfg_data[31:0];
                sha1sh_pkg::CFG_INIT4: init_reg[4] <= cfg_data[31:0];
                sha1sh_pkg::CFG_PRIOR: prior_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // bit count, restarted from the prior block count at message start
    always_comb begin
        count_base = cmd.start ? {prior_reg, 9'd0} : count_reg;
        count_next = count_base + (cmd.add_count ? 64'd8 : 64'd0);
    end

    always_ff @(posedge aclk) begin
        if (cmd.start || cmd.add_count) begin
            count_reg <= count_next;
        end
    end

    // byte source for the block buffer
    always_comb begin
        unique case (cmd.byte_sel)
            sha1sh_pkg::SEL_DATA: byte_in = data_byte;
            sha1sh_pkg::SEL_MARK: byte_in = sha1sh_pkg::PAD_MARK;
            sha1sh_pkg::SEL_LEN:  byte_in = total_reg[63:56];
            default:              byte_in = 8'd0;
        endcase
    end

    // length field, shifted out one byte at a time
    always_ff @(posedge aclk) begin
        if (cmd.latch_total) begin
            total_reg <= count_next;
        end else if (cmd.byte_we && cmd.byte_sel == sha1sh_pkg::SEL_LEN) begin
            total_reg <= {total_reg[55:0], 8'd0};
        end
    end

    // message schedule taken from the oldest word of the window
    always_comb begin
        w_now = buf_reg[511:480];
        w_mix = buf_reg[95:64] ^ buf_reg[255:224] ^ buf_reg[447:416] ^ buf_reg[511:480];
        w_new = {w_mix[30:0], w_mix[31]};
        t_sum = {a_reg[26:0], a_reg[31:27]} + sha1sh_pkg::sha1_f(cmd.grp, b_reg, c_reg, d_reg)
              + e_reg + sha1sh_pkg::sha1_k(cmd.grp) + w_now;
    end

    // block buffer: byte shift while filling, word shift while hashing
    always_ff @(posedge aclk) begin
        if (cmd.byte_we) begin
            buf_reg <= {buf_reg[503:0], byte_in};
        end else if (cmd.round_en) begin
            buf_reg <= {buf_reg[479:0], w_new};
        end
    end

    // working variables
    always_ff @(posedge aclk) begin
        if (cmd.load_work) begin
            a_reg <= cv_reg[0];
            b_reg <= cv_reg[1];
            c_reg <= cv_reg[2];
            d_reg <= cv_reg[3];
            e_reg <= cv_reg[4];
        end else if (cmd.round_en) begin
            a_reg <= t_sum;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    // chaining value
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            for (int i = 0; i < 5; i++) begin
                cv_reg[i] <= init_reg[i];
            end
        end else if (cmd.cv_add) begin
            cv_reg[0] <= cv_reg[0] + a_reg;
            cv_reg[1] <= cv_reg[1] + b_reg;
            cv_reg[2] <= cv_reg[2] + c_reg;
            cv_reg[3] <= cv_reg[3] + d_reg;
            cv_reg[4] <= cv_reg[4] + e_reg;
        end
    end

    // digest word select
    always_comb begin
        unique case (cmd.word_idx)
            3'd1:    digest_word = cv_reg[1];
            3'd2:    digest_word = cv_reg[2];
            3'd3:    digest_word = cv_reg[3];
            3'd4:    digest_word = cv_reg[4];
            default: digest_word = cv_reg[0];
        endcase
    end

endmodule

// ----- src/sha1sh_ctrl.sv -----
// controller: byte position, padding sequence, round counter and digest output
module sha1sh_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_byte_valid,
    input  logic             s_last,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [2:0]       m_word_index,
    output logic             m_end_of_digest,
    output sha1sh_pkg::cmd_t cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_ADD   = 3'd3;
    localparam logic [2:0] ST_PAD   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [5:0] pos_reg, pos_next;
    logic [6:0] rnd_reg, rnd_next;
    logic [2:0] idx_reg, idx_next;
    logic       in_msg_reg, in_msg_next;
    logic       pad_reg, pad_next;
    logic       mark_reg, mark_next;
    logic       len_blk_reg, len_blk_next;
    logic       final_reg, final_next;
    logic       accept;
    logic       active;

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = (state_reg == ST_OUT);
    assign m_word_index    = idx_reg;
    assign m_end_of_digest = (idx_reg == sha1sh_pkg::WORD_LAST);
    assign accept          = s_valid && s_ready;
    assign active          = s_byte_valid || s_last;

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        rnd_next     = rnd_reg;
        idx_next     = idx_reg;
        in_msg_next  = in_msg_reg;
        pad_next     = pad_reg;
        mark_next    = mark_reg;
        len_blk_next = len_blk_reg;
        final_next   = final_reg;

        cmd             = '0;
        cmd.byte_sel    = sha1sh_pkg::SEL_DATA;
        cmd.grp         = sha1sh_pkg::GRP_CH;
        cmd.word_idx    = idx_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept && active) begin
                    cmd.start       = !in_msg_reg;
                    cmd.latch_total = s_last;
                    in_msg_next     = 1'b1;
                    if (s_last) begin
                        pad_next   = 1'b1;
                        mark_next  = 1'b0;
                        final_next = 1'b0;
                    end
                    if (s_byte_valid) begin
                        cmd.byte_we   = 1'b1;
                        cmd.add_count = 1'b1;
                        pos_next      = pos_reg + 6'd1;
                    end
                    if (s_byte_valid && pos_reg == sha1sh_pkg::POS_LAST) begin
                        state_next = ST_LOAD;
                    end else if (s_last) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                cmd.byte_we = 1'b1;
                pos_next    = pos_reg + 6'd1;
                if (!mark_reg) begin
                    cmd.byte_sel = sha1sh_pkg::SEL_MARK;
                    mark_next    = 1'b1;
                    len_blk_next = (pos_reg < sha1sh_pkg::POS_LEN) ||
                                   (pos_reg == sha1sh_pkg::POS_LAST);
                end else if (!len_blk_reg) begin
                    cmd.byte_sel = sha1sh_pkg::SEL_ZERO;
                    if (pos_reg == sha1sh_pkg::POS_LAST) begin
                        len_blk_next = 1'b1;
                    end
                end else if (pos_reg < sha1sh_pkg::POS_LEN) begin
                    cmd.byte_sel = sha1sh_pkg::SEL_ZERO;
                end else begin
                    cmd.byte_sel = sha1sh_pkg::SEL_LEN;
                end
                if (pos_reg == sha1sh_pkg::POS_LAST) begin
                    final_next = mark_reg && len_blk_reg;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                cmd.load_work = 1'b1;
                rnd_next      = 7'd0;
                state_next    = ST_ROUND;
            end
            ST_ROUND: begin
                cmd.round_en = 1'b1;
                if (rnd_reg < 7'd20) begin
                    cmd.grp = sha1sh_pkg::GRP_CH;
                end else if (rnd_reg < 7'd40) begin
                    cmd.grp = sha1sh_pkg::GRP_PAR;
                end else if (rnd_reg < 7'd60) begin
                    cmd.grp = sha1sh_pkg::GRP_MAJ;
                end else begin
                    cmd.grp = sha1sh_pkg::GRP_PR2;
                end
                rnd_next = rnd_reg + 7'd1;
                if (rnd_reg == sha1sh_pkg::ROUND_LAST) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                cmd.cv_add = 1'b1;
                if (final_reg) begin
                    idx_next   = 3'd0;
                    state_next = ST_OUT;
                end else if (pad_reg) begin
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    if (idx_reg == sha1sh_pkg::WORD_LAST) begin
                        idx_next    = 3'd0;
                        in_msg_next = 1'b0;
                        pad_next    = 1'b0;
                        final_next  = 1'b0;
                        state_next  = ST_IDLE;
                    end else begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pos_reg     <= 6'd0;
            rnd_reg     <= 7'd0;
            idx_reg     <= 3'd0;
            in_msg_reg  <= 1'b0;
            pad_reg     <= 1'b0;
            mark_reg    <= 1'b0;
            len_blk_reg <= 1'b0;
            final_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            rnd_reg     <= rnd_next;
            idx_reg     <= idx_next;
            in_msg_reg  <= in_msg_next;
            pad_reg     <= pad_next;
            mark_reg    <= mark_next;
            len_blk_reg <= len_blk_next;
            final_reg   <= final_next;
        end
    end

    // the input side and the digest side are never open together
    assert property (@(posedge aclk) disable iff (!aresetn) !(s_ready && m_valid))
        else $error("input and output open at once");

    // digest words only leave on a block boundary
    assert property (@(posedge aclk) disable iff (!aresetn) m_valid |-> pos_reg == 6'd0)
        else $error("digest shown with a partial block buffered");

    // the last round is followed by the feed-forward add
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND && rnd_reg == sha1sh_pkg::ROUND_LAST) |=> state_reg == ST_ADD)
        else $error("round sequence broken");

    // a stalled digest word keeps its position
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(idx_reg)))
        else $error("digest word index moved under stall");

    // the word index never leaves the digest
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> idx_reg <= sha1sh_pkg::WORD_LAST)
        else $error("digest word index out of range");

endmodule

// ----- src/sha1_stream_hasher_unit.sv -----
// top level of the sha-1 stream hasher
//
// Input channel (s_): one message byte per transaction with s_byte_valid, and
// s_last ending the message; a transaction with s_last and no valid byte just
// finishes it, and one with neither flag is taken and ignored.
// Output channel (m_): five transactions per message, digest words A to E with
// m_word_index 0 to 4 and m_end_of_digest on the last one.
// Bytes are taken one per cycle while the 64-byte buffer fills. A full block
// holds the input for one load step, 80 rounds of the single round unit and
// one feed-forward add. After s_last the padding bytes are shifted in one per
// cycle, followed by one or two block compressions, then the digest words
// appear. A stalled receiver holds the current word, and no new message byte
// is taken until the fifth word has gone.
// The cfg port writes the initial chaining words and the prior block count; a
// new value takes effect at the start of the next message.
// Synchronous reset restores the register defaults and empties the buffer
// position; no clearing pass is needed.
module sha1_stream_hasher_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [sha1sh_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [sha1sh_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [7:0]                          s_data_byte,
    input  logic                                s_byte_valid,
    input  logic                                s_last,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [31:0]                         m_digest_word,
    output logic [2:0]                          m_word_index,
    output logic                                m_end_of_digest
);

    sha1sh_pkg::cmd_t cmd;

    // controller
    sha1sh_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_byte_valid    (s_byte_valid),
        .s_last          (s_last),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_word_index    (m_word_index),
        .m_end_of_digest (m_end_of_digest),
        .cmd             (cmd)
    );

    // datapath
    sha1sh_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .data_byte   (s_data_byte),
        .cmd         (cmd),
        .digest_word (m_digest_word)
    );

endmodule
